### design/fpsa_pkg.sv
// shared constants and control types of the segment allocator
`default_nettype none
package fpsa_pkg;

  localparam int MAX_SEGMENTS_DEF = 64;
  localparam int ADDR_BITS_DEF    = 16;
  localparam int ID_W             = 31;
  localparam int REQ_W            = 17;
  localparam int OUT_ADDR_W       = 16;

  localparam logic [ID_W-1:0]  ID_LAST       = {ID_W{1'b1}};
  localparam logic [REQ_W-1:0] TOTAL_SIZE_RST = 17'd65536;

  localparam logic [1:0] OP_RESET = 2'd0;
  localparam logic [1:0] OP_ALLOC = 2'd1;
  localparam logic [1:0] OP_FREE  = 2'd2;

  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_BEST  = 2'd1;
  localparam logic [1:0] FIT_WORST = 2'd2;

  localparam logic [2:0] ST_RESET   = 3'd0;
  localparam logic [2:0] ST_ALLOC   = 3'd1;
  localparam logic [2:0] ST_NOFIT   = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_FREED   = 3'd4;
  localparam logic [2:0] ST_INVALID = 3'd5;

  localparam logic REG_TOTAL_SIZE = 1'b0;
  localparam logic REG_FIT_POLICY = 1'b1;

  typedef struct packed {
    logic       init_pool;
    logic       latch;
    logic       scan;
    logic       shift_setup;
    logic       shift;
    logic       tail_wr;
    logic       head_wr;
    logic       copy_setup;
    logic       copy;
    logic       free_wr;
    logic       emit;
    logic [2:0] emit_code;
  } ctl_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       up_done;
    logic       down_done;
    logic       found;
    logic       split;
    logic       full;
  } ctl_sts_t;

endpackage
`default_nettype wire

### design/fpsa_ram.sv
// generic single write port ram with registered read
`default_nettype none
module fpsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### design/fpsa_ctrl.sv
// controller state machine of the segment allocator
`default_nettype none
module fpsa_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire fpsa_pkg::ctl_sts_t  sts,
  output fpsa_pkg::ctl_cmd_t       cmd
);

  localparam logic [3:0] S_INIT   = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_DECODE = 4'd2;
  localparam logic [3:0] S_SCAN   = 4'd3;
  localparam logic [3:0] S_SHIFT  = 4'd4;
  localparam logic [3:0] S_TAIL   = 4'd5;
  localparam logic [3:0] S_HEAD   = 4'd6;
  localparam logic [3:0] S_COPY   = 4'd7;
  localparam logic [3:0] S_FREEW  = 4'd8;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_INIT: begin
        cmd.init_pool = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (sts.op) inside
          fpsa_pkg::OP_RESET: begin
            cmd.init_pool = 1'b1;
            cmd.emit      = 1'b1;
            cmd.emit_code = fpsa_pkg::ST_RESET;
            state_nxt     = S_IDLE;
          end
          fpsa_pkg::OP_ALLOC, fpsa_pkg::OP_FREE: begin
            state_nxt = S_SCAN;
          end
          default: begin
            cmd.emit      = 1'b1;
            cmd.emit_code = fpsa_pkg::ST_INVALID;
            state_nxt     = S_IDLE;
          end
        endcase
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.up_done) begin
          if (sts.op == fpsa_pkg::OP_ALLOC) begin
            if (!sts.found) begin
              cmd.emit      = 1'b1;
              cmd.emit_code = fpsa_pkg::ST_NOFIT;
              state_nxt     = S_IDLE;
            end else if (sts.split && sts.full) begin
              cmd.emit      = 1'b1;
              cmd.emit_code = fpsa_pkg::ST_FULL;
              state_nxt     = S_IDLE;
            end else if (sts.split) begin
              cmd.shift_setup = 1'b1;
              state_nxt       = S_SHIFT;
            end else begin
              state_nxt = S_HEAD;
            end
          end else begin
            if (!sts.found) begin
              cmd.emit      = 1'b1;
              cmd.emit_code = fpsa_pkg::ST_INVALID;
              state_nxt     = S_IDLE;
            end else begin
              cmd.copy_setup = 1'b1;
              state_nxt      = S_COPY;
            end
          end
        end
      end
      S_SHIFT: begin
        cmd.shift = 1'b1;
        if (sts.down_done) begin
          state_nxt = S_TAIL;
        end
      end
      S_TAIL: begin
        cmd.tail_wr = 1'b1;
        state_nxt   = S_HEAD;
      end
      S_HEAD: begin
        cmd.head_wr   = 1'b1;
        cmd.emit      = 1'b1;
        cmd.emit_code = fpsa_pkg::ST_ALLOC;
        state_nxt     = S_IDLE;
      end
      S_COPY: begin
        cmd.copy = 1'b1;
        if (sts.up_done) begin
          state_nxt = S_FREEW;
        end
      end
      S_FREEW: begin
        cmd.free_wr   = 1'b1;
        cmd.emit      = 1'b1;
        cmd.emit_code = fpsa_pkg::ST_FREED;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

### design/fpsa_dpath.sv
// datapath: segment table, scan evaluation, entry moves and result registers
`default_nettype none
module fpsa_dpath #(
  parameter int MAX_SEGMENTS = fpsa_pkg::MAX_SEGMENTS_DEF,
  parameter int ADDR_BITS    = fpsa_pkg::ADDR_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire fpsa_pkg::ctl_cmd_t              cmd,
  output fpsa_pkg::ctl_sts_t                   sts,
  input  wire logic [1:0]                      in_operation,
  input  wire logic [fpsa_pkg::REQ_W-1:0]      in_request_size,
  input  wire logic [fpsa_pkg::ID_W-1:0]       in_block_id,
  input  wire logic [fpsa_pkg::REQ_W-1:0]      total_size,
  input  wire logic [1:0]                      fit_policy,
  output logic                                 out_valid,
  output logic [2:0]                           out_status,
  output logic [fpsa_pkg::OUT_ADDR_W-1:0]      out_address,
  output logic [fpsa_pkg::ID_W-1:0]            out_new_id
);

  localparam int unsigned POOL_MAX = (ADDR_BITS < 17) ? (32'd1 << ADDR_BITS) : 32'd131071;
  localparam int SZW  = $clog2(POOL_MAX + 1);
  localparam int STW  = $clog2(POOL_MAX);
  localparam int IW   = $clog2(MAX_SEGMENTS);
  localparam int CW   = $clog2(MAX_SEGMENTS + 1);
  localparam int IDW  = fpsa_pkg::ID_W;
  localparam int RW   = fpsa_pkg::REQ_W;
  localparam int EW   = IDW + 1 + SZW + STW;

  logic [1:0]     op_r;
  logic [RW-1:0]  req_r;
  logic [IDW-1:0] bid_r;
  logic [CW-1:0]  cnt_r;
  logic [IDW-1:0] id_r;
  logic [CW-1:0]  ptr_r;
  logic           rvld_r;
  logic [IW-1:0]  ridx_r;
  logic           found_r;
  logic           inrun_r;
  logic [IW-1:0]  pick_r;
  logic [STW-1:0] pstart_r;
  logic [SZW-1:0] psize_r;
  logic [CW-1:0]  k_r;

  logic           we;
  logic [IW-1:0]  waddr;
  logic [EW-1:0]  wdata;
  logic [EW-1:0]  rdata;
  logic           rd_go;

  logic [STW-1:0] e_start;
  logic [SZW-1:0] e_size;
  logic           e_free;
  logic [IDW-1:0] e_owner;
  logic           take;
  logic           split;
  logic [SZW-1:0] pool_size;
  logic [RW:0]    tail_start;

  fpsa_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_SEGMENTS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (ptr_r[IW-1:0]),
    .rdata (rdata)
  );

  assign e_start = rdata[STW-1:0];
  assign e_size  = rdata[STW +: SZW];
  assign e_free  = rdata[STW + SZW];
  assign e_owner = rdata[EW-1 -: IDW];

  assign split      = RW'(psize_r) > req_r;
  assign tail_start = (RW + 1)'(pstart_r) + (RW + 1)'(req_r);

  always_comb begin
    if (total_size == '0) begin
      pool_size = SZW'(1);
    end else if (32'(total_size) > POOL_MAX) begin
      pool_size = SZW'(POOL_MAX);
    end else begin
      pool_size = SZW'(total_size);
    end
  end

  always_comb begin
    take = 1'b0;
    if (e_free && (req_r != '0) && (RW'(e_size) >= req_r)) begin
      case (fit_policy)
        fpsa_pkg::FIT_FIRST: take = !found_r;
        fpsa_pkg::FIT_BEST:  take = !found_r || (e_size < psize_r);
        fpsa_pkg::FIT_WORST: take = !found_r || (e_size > psize_r);
        default:             take = 1'b0;
      endcase
    end
  end

  always_comb begin
    rd_go = 1'b0;
    if ((cmd.scan || cmd.copy) && (ptr_r < cnt_r)) begin
      rd_go = 1'b1;
    end else if (cmd.shift && (ptr_r > CW'(pick_r))) begin
      rd_go = 1'b1;
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = rdata;
    if (cmd.init_pool) begin
      we    = 1'b1;
      wdata = {{IDW{1'b0}}, 1'b1, pool_size, {STW{1'b0}}};
    end else if (cmd.shift && rvld_r) begin
      we    = 1'b1;
      waddr = ridx_r + IW'(1);
    end else if (cmd.copy && rvld_r) begin
      we    = 1'b1;
      waddr = ridx_r - k_r[IW-1:0];
    end else if (cmd.tail_wr) begin
      we    = 1'b1;
      waddr = pick_r + IW'(1);
      wdata = {{IDW{1'b0}}, 1'b1, SZW'(RW'(psize_r) - req_r), STW'(tail_start)};
    end else if (cmd.head_wr) begin
      we    = 1'b1;
      waddr = pick_r;
      wdata = {id_r, 1'b0, split ? SZW'(req_r) : psize_r, pstart_r};
    end else if (cmd.free_wr) begin
      we    = 1'b1;
      waddr = pick_r;
      wdata = {{IDW{1'b0}}, 1'b1, psize_r, pstart_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= CW'(1);
      id_r      <= IDW'(1);
      rvld_r    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rvld_r    <= rd_go;
      out_valid <= cmd.emit;
      if (cmd.init_pool) begin
        cnt_r <= CW'(1);
        id_r  <= IDW'(1);
      end else if (cmd.head_wr) begin
        if (split) begin
          cnt_r <= cnt_r + CW'(1);
        end
        id_r <= (id_r == fpsa_pkg::ID_LAST) ? IDW'(1) : id_r + IDW'(1);
      end else if (cmd.free_wr) begin
        cnt_r <= cnt_r - k_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    ridx_r <= ptr_r[IW-1:0];
    if (cmd.latch) begin
      op_r    <= in_operation;
      req_r   <= in_request_size;
      bid_r   <= in_block_id;
      found_r <= 1'b0;
      inrun_r <= 1'b0;
      ptr_r   <= '0;
      k_r     <= '0;
      psize_r <= '0;
    end else if (cmd.shift_setup) begin
      ptr_r <= cnt_r - CW'(1);
    end else if (cmd.copy_setup) begin
      ptr_r <= CW'(pick_r) + k_r + CW'(1);
    end else if (rd_go) begin
      ptr_r <= cmd.shift ? ptr_r - CW'(1) : ptr_r + CW'(1);
    end
    if (cmd.scan && rvld_r) begin
      if (op_r == fpsa_pkg::OP_ALLOC) begin
        if (take) begin
          found_r  <= 1'b1;
          pick_r   <= ridx_r;
          pstart_r <= e_start;
          psize_r  <= e_size;
        end
      end else if (!found_r) begin
        if (!e_free && (e_owner == bid_r)) begin
          found_r  <= 1'b1;
          inrun_r  <= 1'b1;
          pick_r   <= ridx_r;
          pstart_r <= e_start;
          psize_r  <= e_size;
        end
      end else if (inrun_r) begin
        if (e_free) begin
          psize_r <= psize_r + e_size;
          k_r     <= k_r + CW'(1);
        end else begin
          inrun_r <= 1'b0;
        end
      end
    end
    if (cmd.emit) begin
      out_status <= cmd.emit_code;
      if (cmd.emit_code == fpsa_pkg::ST_ALLOC) begin
        out_address <= fpsa_pkg::OUT_ADDR_W'(pstart_r);
        out_new_id  <= id_r;
      end else begin
        out_address <= '0;
        out_new_id  <= '0;
      end
    end
  end

  assign sts.op        = op_r;
  assign sts.up_done   = (ptr_r >= cnt_r) && !rvld_r;
  assign sts.down_done = (ptr_r == CW'(pick_r)) && !rvld_r;
  assign sts.found     = found_r;
  assign sts.split     = split;
  assign sts.full      = cnt_r >= CW'(MAX_SEGMENTS);

endmodule
`default_nettype wire

### design/fit_policy_segment_allocator_top.sv
// top level of the segment allocator: config registers, controller and datapath
//
// a command beat is taken at a clock edge with start high and busy low; the
// command carries in_operation (reset pool, allocate, free), in_request_size
// and in_block_id. every command gives exactly one result beat: out_valid is
// high for one cycle with out_status, out_address and out_new_id. the
// receiver cannot hold results off; a new command may be given in the cycle
// the result shows.
// a command walks the segment table through one ram read port, one entry per
// cycle. reset pool and an invalid op end at decode; allocate and free first
// scan the table. no fit, table full and an unknown id end after the scan. a
// split allocate then shifts the entries behind the split one place up and
// writes the tail and head entries; an exact-fit allocate writes the head
// entry only. a free moves the entries behind the merged run down and writes
// the merged free segment. total_size and fit_policy must be written over the
// apb port only while idle; the block itself does not enforce it.
// total_size takes effect at the next pool reset.
// after rst_n the block is busy for one cycle while it writes the initial
// free segment.
`default_nettype none
module fit_policy_segment_allocator_top #(
  parameter int MAX_SEGMENTS = fpsa_pkg::MAX_SEGMENTS_DEF,
  parameter int ADDR_BITS    = fpsa_pkg::ADDR_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [1:0]                      in_operation,
  input  wire logic [fpsa_pkg::REQ_W-1:0]      in_request_size,
  input  wire logic [fpsa_pkg::ID_W-1:0]       in_block_id,
  output logic                                 out_valid,
  output logic [2:0]                           out_status,
  output logic [fpsa_pkg::OUT_ADDR_W-1:0]      out_address,
  output logic [fpsa_pkg::ID_W-1:0]            out_new_id,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [2:0]                      paddr,
  input  wire logic [31:0]                     pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);

  logic [fpsa_pkg::REQ_W-1:0] total_size_r;
  logic [1:0]                 fit_policy_r;
  logic                       cfg_wr;
  fpsa_pkg::ctl_cmd_t         cmd;
  fpsa_pkg::ctl_sts_t         sts;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_size_r <= fpsa_pkg::TOTAL_SIZE_RST;
      fit_policy_r <= fpsa_pkg::FIT_FIRST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        fpsa_pkg::REG_TOTAL_SIZE: total_size_r <= pwdata[fpsa_pkg::REQ_W-1:0];
        fpsa_pkg::REG_FIT_POLICY: fit_policy_r <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      fpsa_pkg::REG_TOTAL_SIZE: prdata = 32'(total_size_r);
      fpsa_pkg::REG_FIT_POLICY: prdata = 32'(fit_policy_r);
      default:                  prdata = '0;
    endcase
  end

  fpsa_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  fpsa_dpath #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .ADDR_BITS    (ADDR_BITS)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_operation    (in_operation),
    .in_request_size (in_request_size),
    .in_block_id     (in_block_id),
    .total_size      (total_size_r),
    .fit_policy      (fit_policy_r),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_address     (out_address),
    .out_new_id      (out_new_id)
  );

endmodule
`default_nettype wire

### design/fpsa_chk.sv
// port checker of the segment allocator and its bind
`default_nettype none
module fpsa_chk (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        start,
  input wire logic                        busy,
  input wire logic                        out_valid,
  input wire logic [2:0]                  out_status,
  input wire logic [fpsa_pkg::OUT_ADDR_W-1:0] out_address,
  input wire logic [fpsa_pkg::ID_W-1:0]   out_new_id
);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted command beat did not raise busy");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result beat while still busy");

  a_result_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("two result beats in a row");

  a_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != fpsa_pkg::ST_ALLOC) |->
      (out_address == '0) && (out_new_id == '0))
    else $error("address or id nonzero on a non-allocate result");

endmodule

bind fit_policy_segment_allocator_top fpsa_chk u_fpsa_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .start       (start),
  .busy        (busy),
  .out_valid   (out_valid),
  .out_status  (out_status),
  .out_address (out_address),
  .out_new_id  (out_new_id)
);
`default_nettype wire

### dv/tb.sv
// testbench for the fit-policy segment allocator: directed and random commands
`timescale 1ns / 100ps
module tb;

  localparam int SEGS = 64;
  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam logic [2:0] ADDR_TOTAL  = 3'd0;
  localparam logic [2:0] ADDR_POLICY = 3'd4;

  typedef struct packed {
    logic [2:0]                status;
    logic [15:0]               address;
    logic [fpsa_pkg::ID_W-1:0] new_id;
  } alloc_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_operation = fpsa_pkg::OP_RESET;
  logic [fpsa_pkg::REQ_W-1:0] in_request_size = '0;
  logic [fpsa_pkg::ID_W-1:0] in_block_id = '0;
  logic out_valid;
  logic [2:0] out_status;
  logic [fpsa_pkg::OUT_ADDR_W-1:0] out_address;
  logic [fpsa_pkg::ID_W-1:0] out_new_id;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  fit_policy_segment_allocator_top i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_operation(in_operation), .in_request_size(in_request_size),
    .in_block_id(in_block_id), .out_valid(out_valid), .out_status(out_status),
    .out_address(out_address), .out_new_id(out_new_id),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #6 clk = ~clk;

  // predictor state
  logic [16:0]               pool_total = fpsa_pkg::TOTAL_SIZE_RST;
  logic [1:0]                pool_policy = fpsa_pkg::FIT_FIRST;
  logic [16:0]               seg_base [SEGS];
  logic [16:0]               seg_len [SEGS];
  bit                        seg_open [SEGS];
  logic [fpsa_pkg::ID_W-1:0] seg_id [SEGS];
  int                        seg_cnt;
  logic [fpsa_pkg::ID_W-1:0] next_id;
  logic [fpsa_pkg::ID_W-1:0] live_ids [$];

  alloc_result_t pending_q [$];
  int errors = 0;
  int accepted = 0;
  int status_seen [8];
  int burst_left = 0;

  function automatic void rebuild_pool();
    logic [16:0] t;
    t = pool_total;
    if (t == 0) t = 1;
    if (t > 17'd65536) t = 17'd65536;
    for (int k = 0; k < SEGS; k++) begin
      seg_base[k] = '0; seg_len[k] = '0; seg_open[k] = 0; seg_id[k] = '0;
    end
    seg_len[0] = t;
    seg_open[0] = 1;
    seg_cnt = 1;
    next_id = 1;
    live_ids.delete();
  endfunction

  function automatic alloc_result_t predict_alloc(logic [16:0] req);
    alloc_result_t r;
    int pick;
    logic [16:0] score;
    bit hit;
    r = '0;
    pick = 0; score = '0; hit = 0;
    r.status = fpsa_pkg::ST_NOFIT;
    if (req == 0) return r;
    for (int k = 0; k < seg_cnt; k++) begin
      if (!seg_open[k] || seg_len[k] < req) continue;
      if (pool_policy == fpsa_pkg::FIT_FIRST) begin
        pick = k; hit = 1; break;
      end else if (pool_policy == fpsa_pkg::FIT_BEST) begin
        if (!hit || seg_len[k] - req < score) begin
          score = seg_len[k] - req; pick = k; hit = 1;
        end
      end else if (pool_policy == fpsa_pkg::FIT_WORST) begin
        if (!hit || seg_len[k] > score) begin
          score = seg_len[k]; pick = k; hit = 1;
        end
      end
    end
    if (!hit) return r;
    if (seg_len[pick] > req) begin
      if (seg_cnt >= SEGS) begin
        r.status = fpsa_pkg::ST_FULL;
        return r;
      end
      for (int k = seg_cnt - 1; k > pick; k--) begin
        seg_base[k+1] = seg_base[k]; seg_len[k+1] = seg_len[k];
        seg_open[k+1] = seg_open[k]; seg_id[k+1] = seg_id[k];
      end
      seg_base[pick+1] = seg_base[pick] + req;
      seg_len[pick+1] = seg_len[pick] - req;
      seg_open[pick+1] = 1;
      seg_id[pick+1] = '0;
      seg_cnt++;
      seg_len[pick] = req;
    end
    seg_open[pick] = 0;
    seg_id[pick] = next_id;
    next_id = (next_id == fpsa_pkg::ID_LAST) ? 1 : next_id + 1;
    live_ids.push_back(seg_id[pick]);
    r.status = fpsa_pkg::ST_ALLOC;
    r.address = seg_base[pick][15:0];
    r.new_id = seg_id[pick];
    return r;
  endfunction

  function automatic alloc_result_t predict_free(logic [fpsa_pkg::ID_W-1:0] id);
    alloc_result_t r;
    int k;
    r = '0;
    r.status = fpsa_pkg::ST_INVALID;
    for (k = 0; k < seg_cnt; k++)
      if (!seg_open[k] && seg_id[k] == id) break;
    if (k >= seg_cnt) return r;
    seg_open[k] = 1;
    seg_id[k] = '0;
    foreach (live_ids[n])
      if (live_ids[n] == id) begin
        live_ids.delete(n);
        break;
      end
    while (k + 1 < seg_cnt && seg_open[k+1]) begin
      seg_len[k] = seg_len[k] + seg_len[k+1];
      for (int j = k + 1; j < seg_cnt - 1; j++) begin
        seg_base[j] = seg_base[j+1]; seg_len[j] = seg_len[j+1];
        seg_open[j] = seg_open[j+1]; seg_id[j] = seg_id[j+1];
      end
      seg_cnt--;
      seg_base[seg_cnt] = '0; seg_len[seg_cnt] = '0;
      seg_open[seg_cnt] = 0; seg_id[seg_cnt] = '0;
    end
    r.status = fpsa_pkg::ST_FREED;
    return r;
  endfunction

  function automatic alloc_result_t predict_command(logic [1:0] op, logic [16:0] req,
                                                    logic [fpsa_pkg::ID_W-1:0] id);
    alloc_result_t r;
    r = '0;
    case (op)
      fpsa_pkg::OP_RESET: begin
        rebuild_pool();
        r.status = fpsa_pkg::ST_RESET;
      end
      fpsa_pkg::OP_ALLOC: r = predict_alloc(req);
      fpsa_pkg::OP_FREE:  r = predict_free(id);
      default:            r.status = fpsa_pkg::ST_INVALID;
    endcase
    return r;
  endfunction

  // one command beat; start stays high when the next beat follows directly
  task automatic send_cmd(logic [1:0] op, logic [16:0] req,
                          logic [fpsa_pkg::ID_W-1:0] id);
    int gap;
    start <= 1'b1;
    in_operation <= op;
    in_request_size <= req;
    in_block_id <= id;
    do @(posedge clk); while (busy);
    pending_q.push_back(predict_command(op, req, id));
    accepted++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      if ($urandom_range(0, 2) != 0) begin
        gap = $urandom_range(1, 8);
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic drain();
    @(posedge clk);
    start <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] addr, logic [31:0] data);
    drain();
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0; paddr <= addr; pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == ADDR_TOTAL) pool_total = data[16:0];
    else if (addr == ADDR_POLICY) pool_policy = data[1:0];
  endtask

  task automatic set_pool(logic [31:0] total, logic [1:0] policy);
    write_reg(ADDR_TOTAL, total);
    write_reg(ADDR_POLICY, {30'd0, policy});
    send_cmd(fpsa_pkg::OP_RESET, '0, '0);
  endtask

  // checker
  always @(posedge clk) begin
    alloc_result_t e;
    if (rst_n && out_valid) begin
      if (pending_q.size() == 0) begin
        $error("result beat with nothing expected: status %0d", out_status);
        errors++;
      end else begin
        e = pending_q.pop_front();
        status_seen[out_status]++;
        if (out_status !== e.status) begin
          $error("status expected %0d actual %0d", e.status, out_status); errors++;
        end
        if (out_address !== e.address) begin
          $error("address expected %0d actual %0d", e.address, out_address); errors++;
        end
        if (out_new_id !== e.new_id) begin
          $error("new_id expected %0d actual %0d", e.new_id, out_new_id); errors++;
        end
      end
    end
  end

  task automatic test_directed();
    send_cmd(fpsa_pkg::OP_ALLOC, 17'd0, '0);
    send_cmd(fpsa_pkg::OP_ALLOC, 17'd65536, '0);
    send_cmd(fpsa_pkg::OP_ALLOC, 17'd1, '0);
    send_cmd(fpsa_pkg::OP_FREE, 17'd1, '0);
    send_cmd(fpsa_pkg::OP_FREE, '0, 31'd1);
    send_cmd(fpsa_pkg::OP_FREE, '0, 31'd1);
    send_cmd(fpsa_pkg::OP_FREE, '0, '0);
    send_cmd(fpsa_pkg::OP_FREE, '0, fpsa_pkg::ID_LAST);
    send_cmd(OP_UNUSED, 17'h1ffff, fpsa_pkg::ID_LAST);
    send_cmd(fpsa_pkg::OP_ALLOC, 17'h1ffff, '0);
    send_cmd(fpsa_pkg::OP_ALLOC, 17'd65536, '0);
    send_cmd(fpsa_pkg::OP_ALLOC, 17'd1, '0);
    send_cmd(fpsa_pkg::OP_RESET, '0, '0);
    set_pool(32'd0, fpsa_pkg::FIT_FIRST);
    send_cmd(fpsa_pkg::OP_ALLOC, 17'd2, '0);
    send_cmd(fpsa_pkg::OP_ALLOC, 17'd1, '0);
    set_pool(32'h1ffff, 2'd3);
    send_cmd(fpsa_pkg::OP_ALLOC, 17'd1, '0);
  endtask

  // ties and policy choice on a pool with holes of sizes 5, 3, 5
  task automatic test_policies();
    for (int p = 0; p < 3; p++) begin
      set_pool(32'd40, p[1:0]);
      send_cmd(fpsa_pkg::OP_ALLOC, 17'd5, '0);
      send_cmd(fpsa_pkg::OP_ALLOC, 17'd2, '0);
      send_cmd(fpsa_pkg::OP_ALLOC, 17'd3, '0);
      send_cmd(fpsa_pkg::OP_ALLOC, 17'd2, '0);
      send_cmd(fpsa_pkg::OP_ALLOC, 17'd5, '0);
      send_cmd(fpsa_pkg::OP_ALLOC, 17'd2, '0);
      send_cmd(fpsa_pkg::OP_FREE, '0, 31'd1);
      send_cmd(fpsa_pkg::OP_FREE, '0, 31'd3);
      send_cmd(fpsa_pkg::OP_FREE, '0, 31'd5);
      send_cmd(fpsa_pkg::OP_ALLOC, 17'd3, '0);
      send_cmd(fpsa_pkg::OP_ALLOC, 17'd4, '0);
    end
  endtask

  task automatic test_table_full();
    set_pool(32'd100, fpsa_pkg::FIT_FIRST);
    repeat (64) send_cmd(fpsa_pkg::OP_ALLOC, 17'd1, '0);
    send_cmd(fpsa_pkg::OP_ALLOC, 17'd37, '0);
    send_cmd(fpsa_pkg::OP_ALLOC, 17'd1, '0);
    send_cmd(fpsa_pkg::OP_FREE, '0, 31'd2);
    send_cmd(fpsa_pkg::OP_FREE, '0, 31'd1);
    send_cmd(fpsa_pkg::OP_ALLOC, 17'd2, '0);
  endtask

  task automatic test_random();
    int sel;
    logic [16:0] req;
    logic [fpsa_pkg::ID_W-1:0] id;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: set_pool(32'd65536, fpsa_pkg::FIT_FIRST);
        1: set_pool(32'd300, fpsa_pkg::FIT_BEST);
        2: set_pool(32'd1, fpsa_pkg::FIT_WORST);
        3: set_pool($urandom_range(64, 4000), fpsa_pkg::FIT_WORST);
        4: set_pool(32'd200, fpsa_pkg::FIT_FIRST);
        default: set_pool($urandom_range(1, 131071), fpsa_pkg::FIT_BEST);
      endcase
      if (phase == 4) drain();
      repeat (60) begin
        sel = $urandom_range(0, 99);
        if (sel < 50) begin
          req = ($urandom_range(0, 9) == 0) ? 17'($urandom) : 17'($urandom_range(1, 40));
          send_cmd(fpsa_pkg::OP_ALLOC, req, 31'($urandom));
        end else if (sel < 85 && live_ids.size() != 0) begin
          id = live_ids[$urandom_range(0, live_ids.size() - 1)];
          send_cmd(fpsa_pkg::OP_FREE, 17'($urandom), id);
        end else if (sel < 93) begin
          send_cmd(fpsa_pkg::OP_FREE, 17'($urandom), 31'($urandom));
        end else if (sel < 97) begin
          send_cmd(fpsa_pkg::OP_RESET, 17'($urandom), 31'($urandom));
        end else begin
          send_cmd(OP_UNUSED, 17'($urandom), 31'($urandom));
        end
      end
    end
  endtask

  initial begin
    rebuild_pool();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_policies();
    test_table_full();
    test_random();
    drain();
    repeat (200) @(posedge clk);
    $display("commands accepted: %0d, allocated %0d, no fit %0d, table full %0d",
             accepted, status_seen[fpsa_pkg::ST_ALLOC], status_seen[fpsa_pkg::ST_NOFIT],
             status_seen[fpsa_pkg::ST_FULL]);
    $display("freed %0d, invalid %0d, pool resets %0d",
             status_seen[fpsa_pkg::ST_FREED], status_seen[fpsa_pkg::ST_INVALID],
             status_seen[fpsa_pkg::ST_RESET]);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
